// File: rtl/vpr_pkg.sv
// ----------------------------------------------------------------------------
// vpr_pkg: shared types and constants for the varispeed platter resampler
// Field widths, op codes, the sequencer state type and the shared ALU command.
// ----------------------------------------------------------------------------
`default_nettype none
package vpr_pkg;
  localparam int AddrBits   = 18;
  localparam int SampleBits = 16;
  localparam int FracBits   = 16;
  localparam int PosBits    = AddrBits + FracBits;
  localparam int SpeedBits  = FracBits + 5;
  localparam int LenBits    = AddrBits + 1;
  localparam int GainBits   = 17;
  localparam int AccBits    = 48;
  localparam int MulBits    = 24;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_SEEK = 2'd2;

  localparam logic [1:0] REG_SPIN  = 2'd0;
  localparam logic [1:0] REG_BRAKE = 2'd1;
  localparam logic [1:0] REG_TOUCH = 2'd2;
  localparam logic [1:0] REG_LEN   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SPEED, ST_POS, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RDW,
    ST_H1, ST_H2, ST_H3, ST_H4, ST_DONE
  } state_t;

  // One multiply-shift-add: res = floor((a*b + d) / 2^sh) + c
  typedef struct packed {
    logic signed [AccBits-1:0] a;
    logic signed [AccBits-1:0] b;
    logic signed [AccBits-1:0] c;
    logic signed [AccBits-1:0] d;
    logic [4:0]                sh;
  } alu_cmd_t;
endpackage
`default_nettype wire

// File: rtl/varispeed_platter_resampler.sv
// ----------------------------------------------------------------------------
// varispeed_platter_resampler: turntable-style varispeed playback
// Loads a stereo track, seeks, ramps platter speed, advances the position and
// interpolates both channels with a cubic Hermite spline.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake         Payload
// s_axis    in   tvalid/tready     tdata, tuser = op
// m_axis    out  tvalid/tready     tdata
// cfg       in   cfg_we            cfg_index, cfg_data
// A load or seek is taken while idle. A tick presents its result after the
// speed pass, four memory reads and the seven passes through the single
// shared multiply-shift-add unit (speed ramp and three Horner steps per
// channel); a tick on a track shorter than four samples skips to ST_DONE.
// Reset is synchronous; speed, position and registers return to reset values.
// Input is not ready while a tick runs or while its result waits on m_axis.
`default_nettype none
module varispeed_platter_resampler
  import vpr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata from bit 0: load_address[18], load_left[16], load_right[16],
  // seek_position[34], touched[1], scratch_velocity[21], motor_speed[21], pad
  input  wire logic [127:0] s_axis_tdata,
  // tuser: op[2]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata from bit 0: out_left[16], out_right[16], position_out[34],
  // speed_out[21], pad
  output logic [87:0]       m_axis_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [18:0]  cfg_data
);
  // Unpack input fields
  logic [AddrBits-1:0]         in_addr;
  logic [31:0]                 in_pair;
  logic [PosBits-1:0]          in_seek;
  logic                        in_touch;
  logic signed [SpeedBits-1:0] in_scratch, in_motor;
  assign in_addr    = s_axis_tdata[17:0];
  assign in_pair    = s_axis_tdata[49:18];
  assign in_seek    = s_axis_tdata[83:50];
  assign in_touch   = s_axis_tdata[84];
  assign in_scratch = s_axis_tdata[105:85];
  assign in_motor   = s_axis_tdata[126:106];

  // Configuration registers with write saturation
  logic [GainBits-1:0] spin_gain, brake_gain, touch_gain;
  logic [LenBits-1:0]  track_len;
  always_ff @(posedge clk) begin
    if (rst) begin
      spin_gain  <= GainBits'(655);
      brake_gain <= GainBits'(655);
      touch_gain <= GainBits'(65536);
      track_len  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPIN:  spin_gain  <= cfg_data < 19'd7 ? GainBits'(7) :
                                 (cfg_data > 19'd65536 ? GainBits'(65536) : cfg_data[16:0]);
        REG_BRAKE: brake_gain <= cfg_data < 19'd7 ? GainBits'(7) :
                                 (cfg_data > 19'd65536 ? GainBits'(65536) : cfg_data[16:0]);
        REG_TOUCH: touch_gain <= cfg_data > 19'd65536 ? GainBits'(65536) : cfg_data[16:0];
        REG_LEN:   track_len  <= cfg_data > 19'(2**AddrBits) ?
                                 LenBits'(2**AddrBits) : cfg_data;
        default:   track_len  <= track_len;
      endcase
    end
  end

  localparam logic signed [AccBits-1:0] SpeedLim = AccBits'(8 << FracBits);
  localparam logic signed [AddrBits+1:0] IdxOne = (AddrBits+2)'(1);

  // Limit a target speed to the platter range
  function automatic logic signed [AccBits-1:0] clamp_spd(
      input logic signed [SpeedBits-1:0] v);
    logic signed [AccBits-1:0] e;
    begin
      e = AccBits'(v);
      if (e > SpeedLim) clamp_spd = SpeedLim;
      else if (e < -SpeedLim) clamp_spd = -SpeedLim;
      else clamp_spd = e;
    end
  endfunction

  state_t state, state_next;
  logic signed [SpeedBits-1:0] speed;
  logic [PosBits-1:0]          pos;
  logic signed [AccBits-1:0]   tgt;
  logic [GainBits-1:0]         gain;
  logic signed [17:0]          y [4][2];   // [tap][channel]
  logic signed [AccBits-1:0]   accl, accr;
  logic [1:0]                  rd_cnt;
  logic [2:0]                  wr_cnt;
  logic signed [SampleBits-1:0] res_l, res_r;
  logic                        accept;

  // Shared unit
  alu_cmd_t                   cmd;
  logic signed [AccBits-1:0]  mres;
  vpr_mac u_mac (.clk(clk), .cmd(cmd), .res(mres));

  // Memory
  logic                 mem_we;
  logic [AddrBits-1:0]  mem_raddr;
  logic [31:0]          mem_rdata;
  vpr_store u_store (
    .clk(clk), .we(mem_we), .waddr(in_addr), .wdata(in_pair),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign mem_we        = accept && (s_axis_tuser == OP_LOAD);

  // Clamped neighbor index for tap rd_cnt
  logic signed [AddrBits+1:0] idx;
  logic [FracBits-1:0]        frac;
  assign frac = pos[FracBits-1:0];
  always_comb begin
    idx = $signed({2'b00, pos[PosBits-1:FracBits]}) + $signed({1'b0, rd_cnt}) - IdxOne;
    if (idx < 0) idx = '0;
    else if (idx > $signed({1'b0, track_len}) - IdxOne)
      idx = $signed({1'b0, track_len}) - IdxOne;
    mem_raddr = idx[AddrBits-1:0];
  end

  // Per-step Hermite coefficients
  function automatic logic signed [AccBits-1:0] coef(input logic [1:0] k,
      input logic signed [17:0] a0, input logic signed [17:0] a1,
      input logic signed [17:0] a2, input logic signed [17:0] a3);
    logic signed [AccBits-1:0] e0, e1, e2, e3, r;
    begin
      e0 = AccBits'(a0); e1 = AccBits'(a1); e2 = AccBits'(a2); e3 = AccBits'(a3);
      case (k)
        2'd0:    r = -e0 + 3*e1 - 3*e2 + e3;
        2'd1:    r = 2*e0 - 5*e1 + 4*e2 - e3;
        2'd2:    r = e2 - e0;
        default: r = 2*e1;
      endcase
      coef = r;
    end
  endfunction

  // Position limit for the tick
  logic signed [AccBits-1:0] maxpos;
  assign maxpos = $signed(AccBits'(track_len) - 2) <<< FracBits;

  // Command for the shared unit; later Horner steps take the last result
  logic chan;
  always_comb begin
    cmd = '0;
    chan = wr_cnt[0];
    case (state)
      ST_SPEED: begin
        cmd.a = tgt - AccBits'(speed);
        cmd.b = AccBits'($signed({1'b0, gain}));
        cmd.c = AccBits'(speed) ;
        cmd.d = AccBits'(32768);
        cmd.sh = 5'd16;
      end
      ST_H2, ST_H3, ST_H4: begin
        cmd.a = (state == ST_H2) ? (chan ? accr : accl) : mres;
        cmd.b = AccBits'($signed({1'b0, frac}));
        cmd.c = coef((state == ST_H2) ? 2'd1 : (state == ST_H3) ? 2'd2 : 2'd3,
                     y[0][chan], y[1][chan], y[2][chan], y[3][chan]);
        cmd.sh = 5'(FracBits);
      end
      default: cmd = '0;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && s_axis_tuser == OP_TICK)
                  state_next = (track_len < LenBits'(4)) ? ST_DONE : ST_SPEED;
      ST_SPEED: state_next = ST_POS;
      ST_POS:   state_next = ST_RD0;
      ST_RD0:   state_next = ST_RD1;
      ST_RD1:   state_next = ST_RD2;
      ST_RD2:   state_next = ST_RD3;
      ST_RD3:   state_next = ST_RDW;
      ST_RDW:   state_next = ST_H1;
      ST_H1:    state_next = ST_H2;
      ST_H2:    state_next = ST_H3;
      ST_H3:    state_next = ST_H4;
      ST_H4:    state_next = wr_cnt[0] ? ST_DONE : ST_H2;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Rounding with the +32768 bias folded in before the shift
  logic signed [AccBits-1:0] spd_raw, hl, hr;
  assign spd_raw = mres;
  function automatic logic signed [SampleBits-1:0] sat(input logic signed [AccBits-1:0] a);
    logic signed [AccBits-1:0] h;
    begin
      h = (a + 1) >>> 1;
      if (h > AccBits'(32767)) sat = 16'sh7fff;
      else if (h < -AccBits'(32768)) sat = 16'sh8000;
      else sat = h[SampleBits-1:0];
    end
  endfunction
  // Right channel ends in the unit output during ST_DONE
  assign hl = accl;
  assign hr = mres;

  // The speed result is in the unit's register in ST_POS, where it is applied.
  // Horner result from ST_Hk lands in the following cycle.
  logic hv;
  logic hch;

  // Datapath registers
  logic [1:0] rd_seq;
  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= '0;
      pos <= '0;
      m_axis_tvalid <= 1'b0;
      rd_cnt <= '0;
      wr_cnt <= '0;
      rd_seq <= '0;
      hv <= 1'b0; hch <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          rd_cnt <= '0; wr_cnt <= '0; rd_seq <= '0;
          if (accept && s_axis_tuser == OP_SEEK) begin
            if (track_len == '0) pos <= in_seek;
            else if (track_len < LenBits'(2)) pos <= '0;
            else if (in_seek > {track_len[AddrBits-1:0] - AddrBits'(2), 16'd0})
              pos <= {track_len[AddrBits-1:0] - AddrBits'(2), 16'd0};
            else pos <= in_seek;
          end
          if (accept && s_axis_tuser == OP_TICK) begin
            res_l <= '0; res_r <= '0;
            if (in_touch) begin
              tgt <= clamp_spd(in_scratch); gain <= touch_gain;
            end else begin
              tgt <= clamp_spd(in_motor);
              gain <= (in_motor == '0) ? brake_gain : spin_gain;
            end
          end
        end
        ST_POS: ;
        ST_RD0, ST_RD1, ST_RD2, ST_RD3: rd_cnt <= rd_cnt + 2'd1;
        default: ;
      endcase
      if (state == ST_RD1 || state == ST_RD2 || state == ST_RD3 || state == ST_RDW) begin
        y[rd_seq][0] <= 18'($signed(mem_rdata[15:0]));
        y[rd_seq][1] <= 18'($signed(mem_rdata[31:16]));
        rd_seq <= rd_seq + 2'd1;
      end
      if (state == ST_H1) begin
        accl <= coef(2'd0, y[0][0], y[1][0], y[2][0], y[3][0]);
        accr <= coef(2'd0, y[0][1], y[1][1], y[2][1], y[3][1]);
      end
      if (state == ST_DONE) m_axis_tvalid <= 1'b1;

      hv  <= (state == ST_H2) || (state == ST_H3) || (state == ST_H4);
      hch <= wr_cnt[0];
      if (state == ST_H4) wr_cnt <= wr_cnt + 3'd1;
      if (state == ST_POS) begin : pos_upd
        logic signed [AccBits-1:0] sp, np;
        sp = spd_raw;
        if (sp > SpeedLim) sp = SpeedLim;
        else if (sp < -SpeedLim) sp = -SpeedLim;
        np = $signed({14'd0, pos}) + sp;
        if (np < 0) begin
          pos <= '0; speed <= '0;
        end else if (np > maxpos) begin
          pos <= maxpos[PosBits-1:0]; speed <= '0;
        end else begin
          pos <= np[PosBits-1:0]; speed <= sp[SpeedBits-1:0];
        end
      end
      if (hv) begin
        if (hch) accr <= mres;
        else     accl <= mres;
      end
      if (state == ST_DONE) begin
        res_l <= (track_len < LenBits'(4)) ? '0 : sat(hl);
        res_r <= (track_len < LenBits'(4)) ? '0 : sat(hr);
      end
    end
  end

  assign m_axis_tdata = {1'b0, speed, pos, res_r, res_l};

  // Checks
  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && track_len >= LenBits'(4)) |->
      ($signed({14'd0, pos}) <= maxpos)) else $error("position past end");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |=> m_axis_tvalid) else $error("result lost");
endmodule
`default_nettype wire

// File: rtl/vpr_mac.sv
// ----------------------------------------------------------------------------
// vpr_mac: shared multiply-shift-add unit
// Registered result of floor((a*b + d) >> sh) + c; a and b use 24 x 24 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module vpr_mac
  import vpr_pkg::*;
(
  input  wire logic                      clk,
  input  wire alu_cmd_t                  cmd,
  output logic signed [AccBits-1:0]      res
);
  logic signed [MulBits-1:0] ma, mb;
  logic signed [AccBits-1:0] mp;
  logic signed [AccBits-1:0] prod;
  assign ma = cmd.a[MulBits-1:0];
  assign mb = cmd.b[MulBits-1:0];
  // Multiply narrow operands, add the bias (arithmetic shift floors)
  assign mp   = ma * mb;
  assign prod = (mp + cmd.d) >>> cmd.sh;
  always_ff @(posedge clk) begin
    res <= prod + cmd.c;
  end
endmodule
`default_nettype wire

// File: rtl/vpr_store.sv
// ----------------------------------------------------------------------------
// vpr_store: stereo sample memory
// One write port, one registered read port; low half left, high half right.
// ----------------------------------------------------------------------------
`default_nettype none
module vpr_store
  import vpr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AddrBits-1:0]   waddr,
  input  wire logic [31:0]           wdata,
  input  wire logic [AddrBits-1:0]   raddr,
  output logic [31:0]                rdata
);
  logic [31:0] mem [2**AddrBits];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
